// ===== hw/rtl/pwm_input_duty_frequency_meter_core_assert.svh =====
// Assertion macros shared by the PWM meter RTL files.
// Depends on nothing; included by the modules that carry checks.
`ifndef PWM_INPUT_DUTY_FREQUENCY_METER_CORE_ASSERT_SVH
`define PWM_INPUT_DUTY_FREQUENCY_METER_CORE_ASSERT_SVH

// Implication check, disabled while reset is asserted.
`define PIDFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pidfm implication check failed");

// Plain invariant, disabled while reset is asserted.
`define PIDFM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("pidfm invariant check failed");

`endif

// ===== hw/rtl/pidfm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the PWM duty and frequency meter. No dependencies.
package pidfm_pkg;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int FILTER_LEN_DEF   = 8;

  // Widths fixed by the item fields.
  localparam int COUNT_WIDTH = 16;
  localparam int PIN_W       = 3;
  localparam int CHAN_W      = 2;
  localparam int DUTY_W      = 14;
  localparam int RATE_W      = 27;
  localparam int RATIO_W     = 17;
  localparam int CFG_IDX_W   = 2;

  localparam int DUTY_SCALE = 10000;
  // Dividend width covers both high*10000 (30 bits) and the tick rate.
  localparam int DIV_W      = 30;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [COUNT_WIDTH-1:0] RATIO_M1_RST  = COUNT_WIDTH'(960 - 1);
  localparam logic [COUNT_WIDTH-1:0] LIMIT_RST     = COUNT_WIDTH'(50000 - 1);
  localparam logic [RATE_W-1:0]      TICK_RATE_RST = RATE_W'(50000);
  localparam logic [RATIO_W-1:0]     RATIO_MAX     = RATIO_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE_RATIO = 2'd0,
    CFG_PERIOD_LIMIT   = 2'd1,
    CFG_TICK_RATE_HZ   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  typedef struct packed {
    logic sample;
    logic rd_load;
    logic div_step;
    logic duty_store;
    logic div_load_freq;
    logic out_load;
  } pidfm_cmd_t;

  typedef struct packed {
    logic per_zero;
    logic div_done;
    logic out_free;
  } pidfm_stat_t;

endpackage

// ===== hw/rtl/pwm_input_duty_frequency_meter_core.sv =====
// PWM input meter: three-channel duty cycle and frequency measurement.
// Input channel (in_valid_i/in_stall_o) carries mode, pin_levels, channel.
// A beat with mode 0 is a sample tick: every channel filters its pin,
// advances its prescaler and counter and captures edges; it returns
// nothing.
// A beat with mode 1 reads one channel and returns one output beat
// (out_valid_o/out_stall_i) with duty, frequency, period and high time.
// A read runs two 30-step divisions on one shared restoring divider
// (one quotient bit per cycle); when the captured period is zero both
// divisions are skipped and duty and frequency read as zero. No new beat
// is taken while a read is in progress.
// The output register holds a beat while the receiver stalls; sample
// ticks keep flowing meanwhile, and a later read waits only at its end.
// Config writes (cfg_valid_i, always ready) set the prescale ratio,
// period limit and tick rate; write them only while the block is idle.
// Reset clears all channel state and loads the default config.
// Depends on pidfm_pkg, pidfm_ctrl, pidfm_datapath.
module pwm_input_duty_frequency_meter_core import pidfm_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FILTER_LEN   = FILTER_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [PIN_W-1:0]       pin_levels_i,
  input  logic [CHAN_W-1:0]      channel_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DUTY_W-1:0]      duty_per_10000_o,
  output logic [RATE_W-1:0]      frequency_hz_o,
  output logic [COUNT_WIDTH-1:0] period_ticks_o,
  output logic [COUNT_WIDTH-1:0] high_ticks_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATE_W-1:0]      cfg_data_i
);

  pidfm_cmd_t  cmd;
  pidfm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pidfm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  pidfm_datapath #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .FILTER_LEN  (FILTER_LEN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pin_levels_i    (pin_levels_i),
    .channel_i       (channel_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .duty_per_10000_o(duty_per_10000_o),
    .frequency_hz_o  (frequency_hz_o),
    .period_ticks_o  (period_ticks_o),
    .high_ticks_o    (high_ticks_o)
  );

endmodule

// ===== hw/rtl/pidfm_chan.sv =====
// One measurement channel: glitch filter, prescaler, period counter and
// edge captures. Depends on pidfm_pkg.
module pidfm_chan import pidfm_pkg::*; #(
  parameter int FILTER_LEN = FILTER_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_i,
  input  logic                   pin_i,
  input  logic [COUNT_WIDTH-1:0] ratio_m1_i,
  input  logic [COUNT_WIDTH-1:0] limit_i,
  output logic [COUNT_WIDTH-1:0] period_o,
  output logic [COUNT_WIDTH-1:0] high_o
);

  logic [2:0]             run_q, run_d;
  logic                   level_q, level_d;
  logic [COUNT_WIDTH-1:0] pre_q, pre_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] per_q, per_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d;

  logic flip, rise, fall, wrap, ovf;

  always_comb begin
    flip = (pin_i != level_q) && (({1'b0, run_q} + 4'd1) >= 4'(FILTER_LEN));
    rise = flip && pin_i;
    fall = flip && !pin_i;
    wrap = (pre_q >= ratio_m1_i);
    ovf  = (cnt_q >= limit_i) || (cnt_q == '1);

    run_d   = run_q;
    level_d = level_q;
    pre_d   = pre_q;
    cnt_d   = cnt_q;
    per_d   = per_q;
    high_d  = high_q;

    if (sample_i) begin
      if (pin_i == level_q) begin
        run_d = '0;
      end else if (flip) begin
        level_d = pin_i;
        run_d   = '0;
      end else begin
        run_d = run_q + 3'd1;
      end

      if (rise) begin
        // restart the period on a rising edge
        per_d = cnt_q;
        cnt_d = '0;
        pre_d = '0;
      end else begin
        if (fall) begin
          high_d = cnt_q;
        end
        if (wrap) begin
          pre_d = '0;
          if (ovf) begin
            // overflow drops both captures, even one taken this beat
            cnt_d  = '0;
            per_d  = '0;
            high_d = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          pre_d = pre_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      level_q <= 1'b0;
      pre_q   <= '0;
      cnt_q   <= '0;
      per_q   <= '0;
      high_q  <= '0;
    end else begin
      run_q   <= run_d;
      level_q <= level_d;
      pre_q   <= pre_d;
      cnt_q   <= cnt_d;
      per_q   <= per_d;
      high_q  <= high_d;
    end
  end

  assign period_o = per_q;
  assign high_o   = high_q;

endmodule

// ===== hw/rtl/pidfm_datapath.sv =====
// Datapath: config registers, channel array, read latch, shared restoring
// divider and output register. Depends on pidfm_pkg and pidfm_chan.
`include "pwm_input_duty_frequency_meter_core_assert.svh"

module pidfm_datapath import pidfm_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FILTER_LEN   = FILTER_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pidfm_cmd_t             cmd_i,
  output pidfm_stat_t            stat_o,
  input  logic [PIN_W-1:0]       pin_levels_i,
  input  logic [CHAN_W-1:0]      channel_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATE_W-1:0]      cfg_data_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [DUTY_W-1:0]      duty_per_10000_o,
  output logic [RATE_W-1:0]      frequency_hz_o,
  output logic [COUNT_WIDTH-1:0] period_ticks_o,
  output logic [COUNT_WIDTH-1:0] high_ticks_o
);

  // Configuration
  logic [COUNT_WIDTH-1:0] ratio_m1_q;
  logic [COUNT_WIDTH-1:0] limit_q;
  logic [RATE_W-1:0]      rate_q;
  logic [RATIO_W-1:0]     ratio_wr;
  logic [COUNT_WIDTH-1:0] ratio_m1_wr;

  always_comb begin
    ratio_wr = cfg_data_i[RATIO_W-1:0];
    if (ratio_wr == '0) begin
      ratio_m1_wr = '0;
    end else if (ratio_wr > RATIO_MAX) begin
      ratio_m1_wr = '1;
    end else begin
      ratio_m1_wr = COUNT_WIDTH'(ratio_wr - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_m1_q <= RATIO_M1_RST;
      limit_q    <= LIMIT_RST;
      rate_q     <= TICK_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRESCALE_RATIO: ratio_m1_q <= ratio_m1_wr;
        CFG_PERIOD_LIMIT:   limit_q    <= cfg_data_i[COUNT_WIDTH-1:0];
        CFG_TICK_RATE_HZ:   rate_q     <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // Channels
  logic [COUNT_WIDTH-1:0] per_arr  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] high_arr [NUM_CHANNELS];

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic pin;
    if (c < PIN_W) begin : g_pin
      assign pin = pin_levels_i[c];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    pidfm_chan #(
      .FILTER_LEN(FILTER_LEN)
    ) u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .sample_i  (cmd_i.sample),
      .pin_i     (pin),
      .ratio_m1_i(ratio_m1_q),
      .limit_i   (limit_q),
      .period_o  (per_arr[c]),
      .high_o    (high_arr[c])
    );
  end

  // Read select; an unknown channel reads as zero
  logic [COUNT_WIDTH-1:0] per_sel, high_sel;

  always_comb begin
    per_sel  = '0;
    high_sel = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if ({1'b0, channel_i} == 3'(c)) begin
        per_sel  = per_arr[c];
        high_sel = high_arr[c];
      end
    end
  end

  logic [COUNT_WIDTH-1:0] per_q, high_q;
  logic [DIV_W-1:0]       quo_q, quo_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DUTY_W-1:0]      duty_q;
  logic [COUNT_WIDTH:0]   rem_sh;
  logic                   fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    fits   = (rem_sh >= {1'b0, per_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (cmd_i.rd_load) begin
      quo_d = DIV_W'(high_sel) * DIV_W'(DUTY_SCALE);
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_load_freq) begin
      quo_d = DIV_W'(rate_q);
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? COUNT_WIDTH'(rem_sh - {1'b0, per_q}) : rem_sh[COUNT_WIDTH-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.rd_load) begin
      per_q  <= per_sel;
      high_q <= high_sel;
    end
    if (cmd_i.duty_store) begin
      duty_q <= (quo_q > DIV_W'(DUTY_SCALE)) ? DUTY_W'(DUTY_SCALE) : quo_q[DUTY_W-1:0];
    end
  end

  // Output register
  logic out_valid_q;
  logic per_zero;

  assign per_zero = (per_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      duty_per_10000_o <= per_zero ? '0 : duty_q;
      frequency_hz_o   <= per_zero ? '0 : quo_q[RATE_W-1:0];
      period_ticks_o   <= per_q;
      high_ticks_o     <= high_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.per_zero = per_zero;
  assign stat_o.div_done = (cnt_q == DIV_CNT_W'(DIV_W));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  `PIDFM_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_i.out_load, !out_valid_q || !out_stall_i)
  `PIDFM_ASSERT_IMP(a_duty_sat, clk_i, rst_ni, out_valid_q, duty_per_10000_o <= DUTY_W'(DUTY_SCALE))
  `PIDFM_ASSERT_IMP(a_zero_per, clk_i, rst_ni, out_valid_q && (period_ticks_o == '0), (duty_per_10000_o == '0) && (frequency_hz_o == '0))

endmodule

// ===== hw/rtl/pidfm_ctrl.sv =====
// Controller: accepts items, sequences the two shared divisions of a
// read and hands the result to the output register. Depends on pidfm_pkg.
`include "pwm_input_duty_frequency_meter_core_assert.svh"

module pidfm_ctrl import pidfm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        mode_i,
  output logic        in_stall_o,
  output pidfm_cmd_t  cmd_o,
  input  pidfm_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DUTY = 4'b0010,
    S_FREQ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept     = in_valid_i && !in_stall_o;
    cmd_o      = '0;
    state_d    = state_q;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.sample  = accept && (mode_i == MODE_SAMPLE);
        cmd_o.rd_load = accept && (mode_i == MODE_READ);
        if (cmd_o.rd_load) begin
          state_d = S_DUTY;
        end
      end
      S_DUTY: begin
        if (stat_i.per_zero || stat_i.div_done) begin
          cmd_o.duty_store    = 1'b1;
          cmd_o.div_load_freq = 1'b1;
          state_d             = S_FREQ;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FREQ: begin
        if (stat_i.per_zero || stat_i.div_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PIDFM_ASSERT_IMP(a_step_bound, clk_i, rst_ni, cmd_o.div_step, !stat_i.div_done)
  `PIDFM_ASSERT_IMP(a_read_runs, clk_i, rst_ni, cmd_o.rd_load, ##1 (state_q == S_DUTY))

endmodule

// ===== tb/sv/pwm_meter_checker.sv =====
// Scoreboard for the PWM duty/frequency meter: mirrors the channel state,
// predicts every read beat and compares it with the output channel.
// Depends on pidfm_pkg.
module pwm_meter_checker import pidfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   mode_i,
  input  logic [PIN_W-1:0]       pin_levels_i,
  input  logic [CHAN_W-1:0]      channel_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DUTY_W-1:0]      duty_per_10000_i,
  input  logic [RATE_W-1:0]      frequency_hz_i,
  input  logic [COUNT_WIDTH-1:0] period_ticks_i,
  input  logic [COUNT_WIDTH-1:0] high_ticks_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [RATE_W-1:0]      cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH         = NUM_CHANNELS_DEF;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [DUTY_W-1:0]      duty;
    logic [RATE_W-1:0]      freq;
    logic [COUNT_WIDTH-1:0] per;
    logic [COUNT_WIDTH-1:0] hi;
  } reading_t;

  logic [RATIO_W-1:0]     ratio_r;
  logic [COUNT_WIDTH-1:0] limit_r;
  logic [RATE_W-1:0]      rate_r;

  logic [2:0]             run_q   [NCH];
  logic                   level_q [NCH];
  logic [COUNT_WIDTH-1:0] pre_q   [NCH];
  logic [COUNT_WIDTH-1:0] cnt_q   [NCH];
  logic [COUNT_WIDTH-1:0] per_q   [NCH];
  logic [COUNT_WIDTH-1:0] hi_q    [NCH];

  reading_t readings_due [$];
  int       errors = 0;

  task automatic clock_channel(input int c, input logic raw);
    logic                rise;
    logic                fall;
    logic [RATIO_W-1:0]  ratio;
    rise = 1'b0;
    fall = 1'b0;
    if (raw == level_q[c]) begin
      run_q[c] = '0;
    end else if (int'(run_q[c]) + 1 >= FILTER_LEN_DEF) begin
      level_q[c] = raw;
      run_q[c]   = '0;
      rise       = raw;
      fall       = !raw;
    end else begin
      run_q[c] = run_q[c] + 3'd1;
    end

    if (rise) begin
      // Rising edge restarts the period; no advance on this tick.
      per_q[c] = cnt_q[c];
      cnt_q[c] = '0;
      pre_q[c] = '0;
    end else begin
      if (fall) hi_q[c] = cnt_q[c];
      if (ratio_r == '0) ratio = RATIO_W'(1);
      else if (ratio_r > RATIO_MAX) ratio = RATIO_MAX;
      else ratio = ratio_r;
      if ({1'b0, pre_q[c]} + RATIO_W'(1) >= ratio) begin
        pre_q[c] = '0;
        if (cnt_q[c] >= limit_r || cnt_q[c] == '1) begin
          // Overflow drops both captures, after any falling-edge capture.
          cnt_q[c] = '0;
          per_q[c] = '0;
          hi_q[c]  = '0;
        end else begin
          cnt_q[c] = cnt_q[c] + 1'b1;
        end
      end else begin
        pre_q[c] = pre_q[c] + 1'b1;
      end
    end
  endtask

  function automatic reading_t reading_of(input logic [CHAN_W-1:0] ch);
    reading_t    r;
    logic [63:0] q;
    r = '0;
    if (int'(ch) < NCH) begin
      r.per = per_q[ch];
      r.hi  = hi_q[ch];
      if (r.per != '0) begin
        q = (64'(r.hi) * DUTY_SCALE) / 64'(r.per);
        if (q > DUTY_SCALE) q = DUTY_SCALE;
        r.duty = q[DUTY_W-1:0];
        q = 64'(rate_r) / 64'(r.per);
        r.freq = q[RATE_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      ratio_r = RATIO_W'(RATIO_M1_RST) + RATIO_W'(1);
      limit_r = LIMIT_RST;
      rate_r  = TICK_RATE_RST;
      for (int c = 0; c < NCH; c++) begin
        run_q[c]   = '0;
        level_q[c] = 1'b0;
        pre_q[c]   = '0;
        cnt_q[c]   = '0;
        per_q[c]   = '0;
        hi_q[c]    = '0;
      end
      readings_due.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PRESCALE_RATIO: ratio_r = cfg_data_i[RATIO_W-1:0];
          CFG_PERIOD_LIMIT:   limit_r = cfg_data_i[COUNT_WIDTH-1:0];
          CFG_TICK_RATE_HZ:   rate_r  = cfg_data_i;
          default: ;
        endcase
      end

      // Retire before queueing so a beat never matches its own request.
      if (out_valid_i && !out_stall_i) begin
        if (readings_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t ns: unexpected output beat, expected none, actual duty %0d freq %0d",
                     $time, duty_per_10000_i, frequency_hz_i);
        end else begin
          want = readings_due.pop_front();
          check_field("duty_per_10000", 32'(want.duty), 32'(duty_per_10000_i));
          check_field("frequency_hz",   32'(want.freq), 32'(frequency_hz_i));
          check_field("period_ticks",   32'(want.per),  32'(period_ticks_i));
          check_field("high_ticks",     32'(want.hi),   32'(high_ticks_i));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_READ) readings_due.push_back(reading_of(channel_i));
        else for (int c = 0; c < NCH; c++) clock_channel(c, pin_levels_i[c]);
      end

      pending_o    <= readings_due.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== tb/sv/tb_pwm_input_duty_frequency_meter_core.sv =====
// Top of the PWM meter testbench: clock, reset, config writes, PWM-like
// pin stimulus with reads, stall patterns and the verdict.
// Depends on pidfm_pkg, pwm_meter_checker and the meter RTL.
module tb_pwm_input_duty_frequency_meter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pidfm_pkg::*;

  localparam int NCH            = NUM_CHANNELS_DEF;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);
  localparam logic [CHAN_W-1:0]    CHAN_NONE      = CHAN_W'(NCH);

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   mode_i;
  logic [PIN_W-1:0]       pin_levels_i;
  logic [CHAN_W-1:0]      channel_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [DUTY_W-1:0]      duty_per_10000_o;
  logic [RATE_W-1:0]      frequency_hz_o;
  logic [COUNT_WIDTH-1:0] period_ticks_o;
  logic [COUNT_WIDTH-1:0] high_ticks_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [RATE_W-1:0]      cfg_data_i;

  int fail_count;
  int pending;
  int burst_left = 0;
  int gap_max    = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;

  logic wave_lvl  [NCH];
  int   wave_left [NCH];
  int   high_len  [NCH];
  int   low_len   [NCH];

  pwm_input_duty_frequency_meter_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .pin_levels_i     (pin_levels_i),
    .channel_i        (channel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_per_10000_o (duty_per_10000_o),
    .frequency_hz_o   (frequency_hz_o),
    .period_ticks_o   (period_ticks_o),
    .high_ticks_o     (high_ticks_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  pwm_meter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .mode_i           (mode_i),
    .pin_levels_i     (pin_levels_i),
    .channel_i        (channel_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_per_10000_i (duty_per_10000_o),
    .frequency_hz_i   (frequency_hz_o),
    .period_ticks_i   (period_ticks_o),
    .high_ticks_i     (high_ticks_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall stretches, or one long hold-off on request.
  initial begin
    int run;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 16);
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                     (cfg_valid_i && cfg_ready_o)))
        idle = 0;
      else
        idle++;
    end
    $display("[pwm_input_duty_frequency_meter_core] ERROR");
    $finish;
  end

  task automatic send_item(input mode_e m, input logic [PIN_W-1:0] p,
                           input logic [CHAN_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    pin_levels_i <= p;
    channel_i    <= c;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic int rand_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 48);
  endfunction

  // Advance each channel's waveform by one tick, with rare glitches.
  task automatic next_wave(output logic [PIN_W-1:0] p);
    p = '0;
    for (int c = 0; c < NCH; c++) begin
      if (wave_left[c] == 0) begin
        wave_lvl[c] = !wave_lvl[c];
        if (wave_lvl[c]) begin
          high_len[c] = rand_len();
          low_len[c]  = rand_len();
        end
        wave_left[c] = wave_lvl[c] ? high_len[c] : low_len[c];
      end
      wave_left[c]--;
      p[c] = wave_lvl[c] ^ ($urandom_range(0, 39) == 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [RATE_W-1:0] ratio_d, input logic [RATE_W-1:0] limit_d,
                              input logic [RATE_W-1:0] rate_d, input bit poke_unused);
    write_reg(CFG_PRESCALE_RATIO, ratio_d);
    write_reg(CFG_PERIOD_LIMIT, limit_d);
    write_reg(CFG_TICK_RATE_HZ, rate_d);
    if (poke_unused) write_reg(CFG_UNUSED_IDX, RATE_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait out every pending read, then let the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input int read_pct, input int gaps,
                           input int stalls, input bit long_hold);
    logic [PIN_W-1:0]  p;
    logic [CHAN_W-1:0] ch;
    int                roll;
    gap_max   = gaps;
    stall_pct = stalls;
    if (long_hold) hold_req = 1'b1;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < read_pct) begin
        ch = ($urandom_range(0, 7) == 0) ? CHAN_NONE : CHAN_W'($urandom_range(0, NCH - 1));
        send_item(MODE_READ, PIN_W'($urandom), ch);
      end else if (roll < read_pct + 5) begin
        send_item(MODE_SAMPLE, PIN_W'($urandom), CHAN_W'($urandom));
      end else begin
        next_wave(p);
        send_item(MODE_SAMPLE, p, CHAN_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_SAMPLE;
    pin_levels_i <= '0;
    channel_i    <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_PRESCALE_RATIO;
    cfg_data_i   <= '0;
    for (int c = 0; c < NCH; c++) begin
      wave_lvl[c]  = 1'b0;
      wave_left[c] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty reads of every channel, then a filtered rise and fall.
    for (int c = 0; c <= NCH; c++) send_item(MODE_READ, '0, CHAN_W'(c));
    repeat (FILTER_LEN_DEF) send_item(MODE_SAMPLE, '1, '0);
    send_item(MODE_READ, '1, '0);
    repeat (FILTER_LEN_DEF) send_item(MODE_SAMPLE, '0, '1);
    send_item(MODE_READ, '0, CHAN_W'(NCH - 1));
    send_item(MODE_READ, '1, CHAN_NONE);

    settle();
    program_regs(RATE_W'(1), RATE_W'(16'hFFFF), RATE_W'(100_000_000), 1'b1);
    run_phase(150, 8, 0, 0, 1'b0);

    settle();
    program_regs(RATE_W'(0), RATE_W'(40), RATE_W'(1), 1'b0);
    run_phase(200, 8, 12, 30, 1'b1);

    settle();
    program_regs(RATE_W'(2), RATE_W'(15), RATE_W'(50_000), 1'b0);
    run_phase(200, 8, 6, 50, 1'b0);

    // Zero limit: every counter advance overflows.
    settle();
    program_regs(RATE_W'(3), RATE_W'(0), '1, 1'b0);
    run_phase(180, 8, 10, 20, 1'b0);

    settle();
    program_regs(RATE_W'(65536), RATE_W'(49_999), RATE_W'(12_345), 1'b0);
    run_phase(120, 10, 4, 20, 1'b0);

    // Ratio above the maximum saturates.
    settle();
    program_regs(RATE_W'(17'h1FFFF), RATE_W'(1), RATE_W'(7), 1'b0);
    run_phase(120, 10, 8, 40, 1'b0);

    // Full-width limit: capture a period, hold the level, then read every channel.
    settle();
    program_regs(RATE_W'(1), RATE_W'(16'hFFFF), RATE_W'($urandom_range(1, 100_000_000)), 1'b0);
    gap_max   = 0;
    stall_pct = 0;
    repeat (20) send_item(MODE_SAMPLE, '1, '0);
    repeat (20) send_item(MODE_SAMPLE, '0, '0);
    repeat (12) send_item(MODE_SAMPLE, '1, '0);
    send_item(MODE_READ, '0, '0);
    repeat (24) send_item(MODE_SAMPLE, '1, '0);
    for (int c = 0; c < NCH; c++) send_item(MODE_READ, '0, CHAN_W'(c));

    // Random settings; upper data bits above each register width are junk.
    repeat (5) begin
      settle();
      program_regs({10'($urandom), 17'($urandom_range(1, 4))},
                   {11'($urandom), 16'($urandom_range(6, 80))},
                   RATE_W'($urandom_range(1, 100_000_000)), 1'b0);
      run_phase(180, $urandom_range(4, 14), $urandom_range(0, 15), $urandom_range(0, 60), 1'b0);
    end

    settle();
    if (fail_count == 0)
      $display("[pwm_input_duty_frequency_meter_core] OK");
    else
      $display("[pwm_input_duty_frequency_meter_core] ERROR");
    $finish;
  end

endmodule
